FILE: rtl/lfvs_pkg.sv
`timescale 1ns / 1ps
package lfvs_pkg;

  localparam int NUM_BUFFERS = 1024;
  localparam int IDX_W       = 10;
  localparam int LNK_W       = IDX_W + 1;

  localparam logic [LNK_W-1:0] LINK_END  = {LNK_W{1'b1}};
  localparam logic [LNK_W-1:0] LINK_NONE = {{(LNK_W-1){1'b1}}, 1'b0};

  typedef enum logic [2:0] {
    CMD_ALLOC = 3'd0,
    CMD_TOUCH = 3'd1,
    CMD_FREE  = 3'd2,
    CMD_SYNC  = 3'd3,
    CMD_PIN   = 3'd4,
    CMD_WAKE  = 3'd5,
    CMD_RSV6  = 3'd6,
    CMD_RSV7  = 3'd7
  } lfvs_cmd_e;

  typedef enum logic [1:0] {
    STS_OK     = 2'd0,
    STS_EMPTY  = 2'd1,
    STS_PINNED = 2'd2,
    STS_RSV    = 2'd3
  } lfvs_sts_e;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_T_CHK, ST_F_CHK, ST_A_FREE, ST_A_FCHK,
    ST_A_LRD, ST_A_LCHK, ST_U1, ST_U2, ST_T_L1, ST_T_L2
  } lfvs_state_e;

  typedef struct packed {
    logic [2:0]       command;
    logic [IDX_W-1:0] buffer_index;
    logic             flag_value;
  } lfvs_req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [IDX_W-1:0] result_index;
    logic             index_valid;
    logic [31:0]      alloc_count;
    logic             wake_writer;
  } lfvs_rsp_t;

  typedef struct packed {
    logic             prev_we;
    logic [IDX_W-1:0] prev_addr;
    logic [LNK_W-1:0] prev_data;
    logic             next_we;
    logic [IDX_W-1:0] next_addr;
    logic [LNK_W-1:0] next_data;
    logic             fnext_we;
    logic [IDX_W-1:0] fnext_addr;
    logic [LNK_W-1:0] fnext_data;
    logic             pin_we;
    logic [IDX_W-1:0] pin_addr;
    logic             pin_data;
  } lfvs_wr_t;

  typedef struct packed {
    logic [LNK_W-1:0] prev;
    logic [LNK_W-1:0] next;
    logic [LNK_W-1:0] fnext;
    logic             pin;
  } lfvs_node_t;

  function automatic logic is_buf(input logic [LNK_W-1:0] v);
    return v < LNK_W'(NUM_BUFFERS);
  endfunction

endpackage

FILE: rtl/lfvs_store.sv
`timescale 1ns / 1ps
module lfvs_store
  import lfvs_pkg::*;
(
  input  logic             clk_i,
  input  lfvs_wr_t         wr_i,
  input  logic             rd_en_i,
  input  logic [IDX_W-1:0] rd_addr_i,
  output lfvs_node_t       rd_o
);

  logic [LNK_W-1:0] prev_mem  [NUM_BUFFERS];
  logic [LNK_W-1:0] next_mem  [NUM_BUFFERS];
  logic [LNK_W-1:0] fnext_mem [NUM_BUFFERS];
  logic             pin_mem   [NUM_BUFFERS];
  lfvs_node_t       rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.prev_we)  prev_mem[wr_i.prev_addr]   <= wr_i.prev_data;
    if (wr_i.next_we)  next_mem[wr_i.next_addr]   <= wr_i.next_data;
    if (wr_i.fnext_we) fnext_mem[wr_i.fnext_addr] <= wr_i.fnext_data;
    if (wr_i.pin_we)   pin_mem[wr_i.pin_addr]     <= wr_i.pin_data;
    if (rd_en_i) begin
      rd_q.prev  <= prev_mem[rd_addr_i];
      rd_q.next  <= next_mem[rd_addr_i];
      rd_q.fnext <= fnext_mem[rd_addr_i];
      rd_q.pin   <= pin_mem[rd_addr_i];
    end
  end

  assign rd_o = rd_q;

endmodule

FILE: rtl/lru_free_list_victim_selector.sv
`timescale 1ns / 1ps
// Buffer replacement engine for 1024 buffers. After reset the block runs a clearing
// pass with busy high. A request is taken when start is high and busy is low; its
// response appears on rsp_o with done_o high for exactly one cycle and must be
// captured then, since the receiver cannot stall the block.
// set_pin, wake, sync_start, unused commands and a touch of the LRU head answer
// straight from the idle state. Touch links the buffer in at the head, unlinking
// it first if listed; free pushes it onto the free list and off the LRU list.
// Allocate pops free-list entries; when it falls back to the LRU list it finds the
// free list empty, scans LRU entries from the tail and unlinks the victim. Every read
// uses the single read port of the link memories, whose read data is registered.
module lru_free_list_victim_selector
  import lfvs_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  lfvs_req_t req_i,
  output logic      done_o,
  output lfvs_rsp_t rsp_o
);

  lfvs_state_e      state_q, state_d;
  lfvs_req_t        req_q, req_d;
  lfvs_rsp_t        rsp_q, rsp_d;
  logic             done_q, done_d;
  logic [IDX_W-1:0] clr_q, clr_d;
  logic [LNK_W-1:0] head_q, head_d, tail_q, tail_d, fhead_q, fhead_d;
  logic [31:0]      cnt_q, cnt_d;
  logic             wake_q, wake_d;
  logic [IDX_W-1:0] node_q, node_d;
  logic [LNK_W-1:0] pv_q, pv_d, nx_q, nx_d;
  lfvs_wr_t         wr;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  lfvs_node_t       rd;
  logic             ok;

  lfvs_store u_store (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_o      (rd)
  );

  assign ok = is_buf({1'b0, req_i.buffer_index});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      done_q  <= 1'b0;
      clr_q   <= '0;
      head_q  <= LINK_END;
      tail_q  <= LINK_END;
      fhead_q <= '0;
      cnt_q   <= '0;
      wake_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      clr_q   <= clr_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      fhead_q <= fhead_d;
      cnt_q   <= cnt_d;
      wake_q  <= wake_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    rsp_q  <= rsp_d;
    node_q <= node_d;
    pv_q   <= pv_d;
    nx_q   <= nx_d;
  end

  always_comb begin
    state_d = state_q;
    req_d   = req_q;
    rsp_d   = rsp_q;
    done_d  = 1'b0;
    clr_d   = clr_q;
    head_d  = head_q;
    tail_d  = tail_q;
    fhead_d = fhead_q;
    cnt_d   = cnt_q;
    wake_d  = wake_q;
    node_d  = node_q;
    pv_d    = pv_q;
    nx_d    = nx_q;
    wr      = '0;
    rd_en   = 1'b0;
    rd_addr = node_q;

    case (state_q)
      ST_CLEAR: begin
        wr.prev_we    = 1'b1;
        wr.prev_addr  = clr_q;
        wr.prev_data  = LINK_NONE;
        wr.next_we    = 1'b1;
        wr.next_addr  = clr_q;
        wr.next_data  = LINK_NONE;
        wr.fnext_we   = 1'b1;
        wr.fnext_addr = clr_q;
        wr.fnext_data = (clr_q == IDX_W'(NUM_BUFFERS - 1)) ? LINK_END
                                                            : {1'b0, clr_q} + 1'b1;
        wr.pin_we     = 1'b1;
        wr.pin_addr   = clr_q;
        wr.pin_data   = 1'b0;
        clr_d         = clr_q + 1'b1;
        if (clr_q == IDX_W'(NUM_BUFFERS - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        rd_en   = 1'b1;
        rd_addr = req_i.buffer_index;
        if (start) begin
          req_d  = req_i;
          node_d = req_i.buffer_index;
          rsp_d  = '0;
          rsp_d.alloc_count = cnt_q;
          case (lfvs_cmd_e'(req_i.command))
            CMD_ALLOC: begin
              cnt_d             = cnt_q + 32'd1;
              rsp_d.alloc_count = cnt_q + 32'd1;
              rsp_d.wake_writer = wake_q;
              wake_d            = 1'b0;
              state_d           = ST_A_FREE;
            end
            CMD_TOUCH: begin
              if (ok && ({1'b0, req_i.buffer_index} != head_q)) state_d = ST_T_CHK;
              else done_d = 1'b1;
            end
            CMD_FREE: begin
              if (ok) state_d = ST_F_CHK;
              else done_d = 1'b1;
            end
            CMD_SYNC: begin
              if (is_buf(tail_q)) begin
                rsp_d.result_index = tail_q[IDX_W-1:0];
                rsp_d.index_valid  = 1'b1;
              end
              cnt_d  = '0;
              done_d = 1'b1;
            end
            CMD_PIN: begin
              wr.pin_we   = ok;
              wr.pin_addr = req_i.buffer_index;
              wr.pin_data = req_i.flag_value;
              done_d      = 1'b1;
            end
            CMD_WAKE: begin
              wake_d = req_i.flag_value;
              done_d = 1'b1;
            end
            default: done_d = 1'b1;
          endcase
        end
      end
      ST_T_CHK: begin
        if (rd.prev != LINK_NONE) begin
          pv_d    = rd.prev;
          nx_d    = rd.next;
          state_d = ST_U1;
        end else begin
          state_d = ST_T_L1;
        end
      end
      ST_F_CHK: begin
        if (rd.fnext != LINK_NONE) begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          wr.fnext_we   = 1'b1;
          wr.fnext_addr = node_q;
          wr.fnext_data = fhead_q;
          fhead_d       = {1'b0, node_q};
          if (rd.prev != LINK_NONE) begin
            pv_d    = rd.prev;
            nx_d    = rd.next;
            state_d = ST_U1;
          end else begin
            done_d  = 1'b1;
            state_d = ST_IDLE;
          end
        end
      end
      ST_A_FREE: begin
        if (is_buf(fhead_q)) begin
          rd_en   = 1'b1;
          rd_addr = fhead_q[IDX_W-1:0];
          state_d = ST_A_FCHK;
        end else if (is_buf(tail_q)) begin
          node_d  = tail_q[IDX_W-1:0];
          state_d = ST_A_LRD;
        end else begin
          rsp_d.status = STS_EMPTY;
          done_d       = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      ST_A_FCHK: begin
        fhead_d       = rd.fnext;
        wr.fnext_we   = 1'b1;
        wr.fnext_addr = fhead_q[IDX_W-1:0];
        wr.fnext_data = LINK_NONE;
        if (!rd.pin && (rd.next == LINK_NONE)) begin
          rsp_d.result_index = fhead_q[IDX_W-1:0];
          rsp_d.index_valid  = 1'b1;
          done_d             = 1'b1;
          state_d            = ST_IDLE;
        end else begin
          state_d = ST_A_FREE;
        end
      end
      ST_A_LRD: begin
        rd_en   = 1'b1;
        rd_addr = node_q;
        state_d = ST_A_LCHK;
      end
      ST_A_LCHK: begin
        if (!rd.pin) begin
          pv_d    = rd.prev;
          nx_d    = rd.next;
          state_d = ST_U1;
        end else if (is_buf(rd.prev)) begin
          node_d  = rd.prev[IDX_W-1:0];
          state_d = ST_A_LRD;
        end else begin
          rsp_d.status = STS_PINNED;
          done_d       = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      ST_U1: begin
        if (!is_buf(pv_q)) head_d = nx_q;
        if (!is_buf(nx_q)) tail_d = pv_q;
        wr.prev_we   = 1'b1;
        wr.prev_addr = node_q;
        wr.prev_data = LINK_NONE;
        wr.next_we   = is_buf(pv_q);
        wr.next_addr = pv_q[IDX_W-1:0];
        wr.next_data = nx_q;
        state_d      = ST_U2;
      end
      ST_U2: begin
        wr.next_we   = 1'b1;
        wr.next_addr = node_q;
        wr.next_data = LINK_NONE;
        wr.prev_we   = is_buf(nx_q);
        wr.prev_addr = nx_q[IDX_W-1:0];
        wr.prev_data = pv_q;
        if (lfvs_cmd_e'(req_q.command) == CMD_TOUCH) begin
          state_d = ST_T_L1;
        end else begin
          if (lfvs_cmd_e'(req_q.command) == CMD_ALLOC) begin
            rsp_d.result_index = node_q;
            rsp_d.index_valid  = 1'b1;
          end
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_T_L1: begin
        wr.prev_we   = 1'b1;
        wr.prev_addr = node_q;
        wr.prev_data = LINK_END;
        wr.next_we   = 1'b1;
        wr.next_addr = node_q;
        wr.next_data = head_q;
        state_d      = ST_T_L2;
      end
      ST_T_L2: begin
        if (is_buf(head_q)) begin
          wr.prev_we   = 1'b1;
          wr.prev_addr = head_q[IDX_W-1:0];
          wr.prev_data = {1'b0, node_q};
        end else begin
          tail_d = {1'b0, node_q};
        end
        head_d  = {1'b0, node_q};
        done_d  = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("response while busy");
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || done_o)) else $error("request dropped");
  a_fail_no_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status != STS_OK) |-> !rsp_o.index_valid)
    else $error("failed allocate with index");
  a_head_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!busy && !done_o && state_q == ST_IDLE) |-> (is_buf(head_q) == is_buf(tail_q)))
    else $error("lru head and tail disagree");

endmodule

FILE: bench/lru_free_list_victim_selector_tb.sv
`timescale 1ns / 1ps
module lru_free_list_victim_selector_tb;
  import lfvs_pkg::*;

  localparam int unsigned END_MARK   = 32'hFFFF_FFFF;
  localparam int unsigned NOT_LINKED = 32'hFFFF_FFFE;
  localparam int          CYCLE_LIMIT = 10_000_000;

  typedef struct {
    lfvs_req_t req;
    bit        drain;
  } pending_req_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  lfvs_req_t req_i = '0;
  logic      done_o;
  lfvs_rsp_t rsp_o;

  lru_free_list_victim_selector DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .req_i (req_i),
    .done_o(done_o),
    .rsp_o (rsp_o)
  );

  always #1 clk_i = ~clk_i;

  int unsigned toward_head[NUM_BUFFERS];
  int unsigned toward_tail[NUM_BUFFERS];
  int unsigned free_link[NUM_BUFFERS];
  bit          pin_flag[NUM_BUFFERS];
  int unsigned mru_buf;
  int unsigned lru_buf;
  int unsigned free_top;
  logic [31:0] alloc_total;
  bit          wake_armed;
  bit          took_from_lru;

  pending_req_t request_q[$];
  lfvs_rsp_t    due_rsp[$];
  int           issued;
  int           answered;
  int           errors;
  int           cycles;
  int           pause;
  int           burst_left;
  int unsigned  last_victim;
  int           n_items;
  int           evictions;

  function automatic bit in_pool(int unsigned v);
    return v < NUM_BUFFERS;
  endfunction

  function automatic void lru_remove(int unsigned b);
    int unsigned nx;
    int unsigned pv;
    nx = toward_tail[b];
    pv = toward_head[b];
    if (pv == NOT_LINKED) return;
    if (!in_pool(pv)) mru_buf = nx;
    if (!in_pool(nx)) lru_buf = pv;
    toward_head[b] = NOT_LINKED;
    toward_tail[b] = NOT_LINKED;
    if (in_pool(pv)) toward_tail[pv] = nx;
    if (in_pool(nx)) toward_head[nx] = pv;
  endfunction

  function automatic lfvs_rsp_t pool_step(lfvs_req_t q);
    lfvs_rsp_t   r;
    int unsigned b;
    int unsigned v;
    r = '0;
    r.status = STS_OK;
    r.alloc_count = alloc_total;
    b = q.buffer_index;
    took_from_lru = 1'b0;
    case (lfvs_cmd_e'(q.command))
      CMD_ALLOC: begin
        alloc_total = alloc_total + 32'd1;
        r.alloc_count = alloc_total;
        if (wake_armed) begin
          wake_armed = 1'b0;
          r.wake_writer = 1'b1;
        end
        for (int s = 0; s < NUM_BUFFERS && in_pool(free_top); s++) begin
          v = free_top;
          free_top = free_link[v];
          free_link[v] = NOT_LINKED;
          if (!pin_flag[v] && toward_tail[v] == NOT_LINKED) begin
            r.result_index = IDX_W'(v);
            r.index_valid = 1'b1;
            return r;
          end
        end
        if (!in_pool(lru_buf)) begin
          r.status = STS_EMPTY;
          return r;
        end
        v = lru_buf;
        for (int s = 0; s < NUM_BUFFERS; s++) begin
          if (!pin_flag[v]) begin
            lru_remove(v);
            r.result_index = IDX_W'(v);
            r.index_valid = 1'b1;
            took_from_lru = 1'b1;
            return r;
          end
          if (!in_pool(toward_head[v])) break;
          v = toward_head[v];
        end
        r.status = STS_PINNED;
      end
      CMD_TOUCH: begin
        if (in_pool(b) && b != mru_buf) begin
          lru_remove(b);
          toward_head[b] = END_MARK;
          toward_tail[b] = mru_buf;
          if (in_pool(mru_buf)) toward_head[mru_buf] = b;
          else lru_buf = b;
          mru_buf = b;
        end
      end
      CMD_FREE: begin
        if (in_pool(b) && free_link[b] == NOT_LINKED) begin
          free_link[b] = free_top;
          free_top = b;
          lru_remove(b);
        end
      end
      CMD_SYNC: begin
        if (in_pool(lru_buf)) begin
          r.result_index = IDX_W'(lru_buf);
          r.index_valid = 1'b1;
        end
        alloc_total = '0;
      end
      CMD_PIN: if (in_pool(b)) pin_flag[b] = q.flag_value;
      CMD_WAKE: wake_armed = q.flag_value;
      default: ;
    endcase
    return r;
  endfunction

  task automatic add_req(lfvs_cmd_e cmd, int unsigned idx, bit flag, bit drain = 1'b0);
    pending_req_t p;
    lfvs_rsp_t    r;
    p.req.command = cmd;
    p.req.buffer_index = idx[IDX_W-1:0];
    p.req.flag_value = flag;
    p.drain = drain;
    r = pool_step(p.req);
    if (cmd == CMD_ALLOC && r.index_valid) last_victim = r.result_index;
    if (took_from_lru) evictions++;
    request_q.push_back(p);
    due_rsp.push_back(r);
    n_items++;
  endtask

  task automatic lru_members(output int unsigned m[$]);
    int unsigned v;
    m = {};
    v = lru_buf;
    while (in_pool(v) && m.size() < NUM_BUFFERS) begin
      m.push_back(v);
      v = toward_head[v];
    end
  endtask

  function automatic int unsigned pick_buffer();
    int s;
    s = $urandom_range(0, 9);
    if (s < 4) return last_victim;
    if (s < 6 && in_pool(free_top) && free_top + 15 < NUM_BUFFERS)
      return free_top + $urandom_range(0, 15);
    if (s == 6) return $urandom_range(0, 1) ? NUM_BUFFERS - 1 : 0;
    return $urandom_range(0, NUM_BUFFERS - 1);
  endfunction

  task automatic report(string what, longint unsigned got, longint unsigned want);
    errors++;
    $display("%0t: %s got %0h want %0h", $realtime, what, got, want);
  endtask

  function automatic int draw_gap();
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      burst_left = 30;
      return 0;
    end
    return $urandom_range(0, 9);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      req_i <= '0;
      pause = 0;
    end else begin
      if (start && !busy) begin
        issued++;
        pause = draw_gap();
      end
      if (start && busy) begin
      end else if (pause > 0) begin
        pause--;
        start <= 1'b0;
      end else if (request_q.size() != 0 && !(request_q[0].drain && answered != issued)) begin
        req_i <= request_q[0].req;
        start <= 1'b1;
        void'(request_q.pop_front());
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    lfvs_rsp_t want;
    if (rst_ni && done_o) begin
      if (answered >= issued || due_rsp.size() == 0) begin
        report("unexpected response, status", rsp_o.status, 0);
      end else begin
        want = due_rsp.pop_front();
        answered++;
        if (rsp_o.status !== want.status) report("status", rsp_o.status, want.status);
        if (rsp_o.result_index !== want.result_index)
          report("result_index", rsp_o.result_index, want.result_index);
        if (rsp_o.index_valid !== want.index_valid)
          report("index_valid", rsp_o.index_valid, want.index_valid);
        if (rsp_o.alloc_count !== want.alloc_count)
          report("alloc_count", rsp_o.alloc_count, want.alloc_count);
        if (rsp_o.wake_writer !== want.wake_writer)
          report("wake_writer", rsp_o.wake_writer, want.wake_writer);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("lru_free_list_victim_selector_tb NOT OK");
      $finish;
    end
  end

  initial begin
    int unsigned m[$];
    int          r;
    for (int i = 0; i < NUM_BUFFERS; i++) begin
      toward_head[i] = NOT_LINKED;
      toward_tail[i] = NOT_LINKED;
      free_link[i] = (i + 1 < NUM_BUFFERS) ? i + 1 : END_MARK;
      pin_flag[i] = 1'b0;
    end
    mru_buf = END_MARK;
    lru_buf = END_MARK;
    free_top = 0;
    alloc_total = '0;
    wake_armed = 1'b0;

    add_req(CMD_SYNC, 0, 1'b0);
    add_req(CMD_ALLOC, 0, 1'b0);
    add_req(CMD_TOUCH, 0, 1'b0);
    add_req(CMD_TOUCH, NUM_BUFFERS - 1, 1'b1);
    add_req(CMD_TOUCH, NUM_BUFFERS - 1, 1'b0);
    add_req(CMD_SYNC, 0, 1'b0);
    add_req(CMD_FREE, NUM_BUFFERS - 1, 1'b0);
    add_req(CMD_FREE, NUM_BUFFERS - 1, 1'b0);
    add_req(CMD_PIN, 1, 1'b1);
    add_req(CMD_TOUCH, 1, 1'b0);
    add_req(CMD_ALLOC, 0, 1'b0);
    add_req(CMD_PIN, 1, 1'b0);
    add_req(CMD_WAKE, 0, 1'b1);
    add_req(CMD_ALLOC, 0, 1'b0);
    add_req(CMD_WAKE, 0, 1'b1);
    add_req(CMD_WAKE, 0, 1'b0);
    add_req(CMD_ALLOC, 0, 1'b0);
    add_req(CMD_RSV6, NUM_BUFFERS - 1, 1'b1);
    add_req(CMD_RSV7, 0, 1'b0);
    add_req(CMD_FREE, 0, 1'b0);
    add_req(CMD_ALLOC, 0, 1'b0);
    add_req(CMD_TOUCH, 5, 1'b0);
    add_req(CMD_SYNC, 0, 1'b1);
    add_req(CMD_SYNC, 0, 1'b0, 1'b1);

    n_items = 0;
    evictions = 0;
    while (n_items < 800) begin
      lru_members(m);
      if (!in_pool(free_top) && m.size() >= 1 && m.size() <= 6
          && $urandom_range(0, 9) == 0) begin
        foreach (m[k]) add_req(CMD_PIN, m[k], 1'b1, k == 0);
        add_req(CMD_ALLOC, 0, 1'b0);
        foreach (m[k]) add_req(CMD_PIN, m[k], 1'b0);
      end else if (!in_pool(free_top) && m.size() <= 4 && $urandom_range(0, 9) == 0) begin
        for (int k = 0; k <= m.size(); k++) add_req(CMD_ALLOC, 0, 1'b0);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 45) add_req(CMD_ALLOC, $urandom_range(0, NUM_BUFFERS - 1),
                            1'($urandom_range(0, 1)), $urandom_range(0, 99) == 0);
        else if (r < 70) add_req(CMD_TOUCH, pick_buffer(), 1'($urandom_range(0, 1)));
        else if (r < 77) add_req(CMD_FREE, pick_buffer(), 1'($urandom_range(0, 1)));
        else if (r < 85) add_req(CMD_PIN, pick_buffer(), $urandom_range(0, 9) < 4);
        else if (r < 90) add_req(CMD_SYNC, pick_buffer(), 1'($urandom_range(0, 1)));
        else if (r < 96) add_req(CMD_WAKE, pick_buffer(), 1'($urandom_range(0, 1)));
        else add_req($urandom_range(0, 1) ? CMD_RSV6 : CMD_RSV7,
                     $urandom_range(0, NUM_BUFFERS - 1), 1'($urandom_range(0, 1)));
      end
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (request_q.size() != 0 || start || answered != issued) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (errors == 0 && due_rsp.size() == 0) begin
      $display("lru_free_list_victim_selector_tb OK");
    end else begin
      $display("lru_free_list_victim_selector_tb NOT OK");
    end
    $finish;
  end

endmodule

FILE: lru_free_list_victim_selector.f
rtl/lfvs_pkg.sv
rtl/lfvs_store.sv
rtl/lru_free_list_victim_selector.sv
bench/lru_free_list_victim_selector_tb.sv
